[rtl/varint_phrase_codec_macros.svh]
// ---------------------------------------------------------------------------
// varint phrase codec assertion macros
// Shared concurrent assertion helpers for the codec RTL.
// ---------------------------------------------------------------------------
`ifndef VARINT_PHRASE_CODEC_MACROS_SVH
`define VARINT_PHRASE_CODEC_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define VPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define VPC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define VPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define VPC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/vpc_pkg.sv]
// ---------------------------------------------------------------------------
// vpc_pkg
// Types and constants shared by the varint phrase codec modules.
// ---------------------------------------------------------------------------
`default_nettype none

package vpc_pkg;

	localparam int WordW   = 32;
	localparam int ShiftW  = 6;
	localparam int MaxRun  = 6;
	localparam int CntW    = 3;
	localparam int NumGrp  = 5;

	localparam logic [7:0]        ContBit     = 8'h80;
	localparam logic [7:0]        PayloadMask = 8'h7f;
	localparam logic [7:0]        Terminator  = 8'h00;
	localparam logic [ShiftW-1:0] ShiftLimit  = 6'd35;
	localparam logic [ShiftW-1:0] ShiftStep   = 6'd7;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} dir_mode_t;

	typedef struct packed {
		logic [WordW-1:0] in_word;
		logic             has_word;
		logic             close_phrase;
		logic [7:0]       in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [WordW-1:0] out_word;
		logic             word_valid;
		logic             phrase_done;
		logic             run_last;
	} out_item_t;

	// results caused by one item, entry 0 goes out first
	typedef struct packed {
		logic [CntW-1:0]              cnt;
		out_item_t [MaxRun-1:0]       ents;
	} run_t;

endpackage

`default_nettype wire

[rtl/vpc_encode.sv]
// ---------------------------------------------------------------------------
// vpc_encode
// Builds one encode item's run: varint of word+1 and/or the terminator.
// ---------------------------------------------------------------------------
`default_nettype none

module vpc_encode
	import vpc_pkg::*;
(
	input  wire in_item_t item,
	output run_t          run
);

	logic [WordW:0]               val;
	logic [NumGrp-1:0][6:0]       grp;
	logic [CntW-1:0]              nb;
	logic [CntW-1:0]              nbw;
	logic [CntW-1:0]              cnt;

	// 33-bit value so that the all-ones word wraps into a fifth group
	assign val = {1'b0, item.in_word} + {{WordW{1'b0}}, 1'b1};

	always_comb begin
		for (int g = 0; g < NumGrp - 1; g++) begin
			grp[g] = val[7*g +: 7];
		end
		grp[NumGrp-1] = {2'b00, val[WordW:28]};
	end

	// number of varint bytes: highest nonzero group plus one
	always_comb begin
		nb = 3'd1;
		for (int g = 1; g < NumGrp; g++) begin
			if (grp[g] != 7'd0) begin
				nb = CntW'(g + 1);
			end
		end
	end

	assign nbw = item.has_word ? nb : '0;
	assign cnt = nbw + {2'b00, item.close_phrase};

	// fill the run entries
	always_comb begin
		run      = '0;
		run.cnt  = cnt;
		for (int i = 0; i < NumGrp; i++) begin
			if (CntW'(i) < nbw) begin
				run.ents[i].out_byte = (CntW'(i + 1) < nb) ?
					(ContBit | {1'b0, grp[i]}) : {1'b0, grp[i]};
			end
		end
		if (item.close_phrase) begin
			run.ents[nbw].out_byte    = Terminator;
			run.ents[nbw].phrase_done = 1'b1;
		end
		if (cnt != '0) begin
			run.ents[cnt - 3'd1].run_last = 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/vpc_decode.sv]
// ---------------------------------------------------------------------------
// vpc_decode
// Group accumulator for decode mode; one byte in, zero or one word out.
// ---------------------------------------------------------------------------
`default_nettype none

module vpc_decode
	import vpc_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             take,
	input  wire [7:0]       in_byte,
	output run_t            run
);

	logic [WordW-1:0]  acc_q;
	logic [ShiftW-1:0] shift_q;
	logic              open_q;

	logic [WordW-1:0]  payload;
	logic [WordW-1:0]  acc_new;
	logic              is_term;
	logic              is_end;

	assign is_term = (in_byte == Terminator);
	assign is_end  = !in_byte[7];

	// payload bits at or above bit 32 are dropped
	always_comb begin
		payload = '0;
		if (shift_q < 6'd32) begin
			payload = {24'd0, in_byte & PayloadMask} << shift_q[4:0];
		end
	end

	assign acc_new = acc_q | payload;

	// result for this byte
	always_comb begin
		run = '0;
		if (is_term) begin
			run.cnt                 = 3'd1;
			run.ents[0].out_word    = open_q ? (acc_q - 32'd1) : '0;
			run.ents[0].word_valid  = open_q;
			run.ents[0].phrase_done = 1'b1;
			run.ents[0].run_last    = 1'b1;
		end else if (is_end) begin
			run.cnt                 = 3'd1;
			run.ents[0].out_word    = acc_new - 32'd1;
			run.ents[0].word_valid  = 1'b1;
			run.ents[0].run_last    = 1'b1;
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			shift_q <= '0;
			open_q  <= 1'b0;
		end else if (take) begin
			if (is_term || is_end) begin
				acc_q   <= '0;
				shift_q <= '0;
				open_q  <= 1'b0;
			end else begin
				acc_q  <= acc_new;
				open_q <= 1'b1;
				if (shift_q < ShiftLimit) begin
					shift_q <= shift_q + ShiftStep;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/vpc_run_buf.sv]
// ---------------------------------------------------------------------------
// vpc_run_buf
// Run and output registers; sends one result item per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

`include "varint_phrase_codec_macros.svh"

module vpc_run_buf
	import vpc_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             load,
	input  wire run_t       run,
	output logic            can_load,
	output logic            out_valid,
	input  wire             out_stall,
	output out_item_t       out_item
);

	out_item_t [MaxRun-1:0] ent_s1;
	logic [CntW-1:0]        cnt_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic out_free;
	logic take;

	assign out_free  = !out_valid_q || !out_stall;
	assign take      = out_free && (cnt_q != '0);
	assign can_load  = (cnt_q == '0) || ((cnt_q == 3'd1) && out_free);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// run entries, shifted toward entry 0 as they leave
	always_ff @(posedge clk) begin
		if (load) begin
			ent_s1 <= run.ents;
		end else if (take) begin
			for (int i = 0; i < MaxRun - 1; i++) begin
				ent_s1[i] <= ent_s1[i+1];
			end
			ent_s1[MaxRun-1] <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= ent_s1[0];
		end
	end

	`VPC_NEVER(a_cnt_range, clk, arst_n, cnt_q > 3'(MaxRun), "run count above run depth")
	`VPC_NEVER(a_load_busy, clk, arst_n, load && (cnt_q > 3'd1), "item loaded over a pending run")
	`VPC_ASSERT(a_fill_out, clk, arst_n, take |=> out_valid_q, "pending result not moved out")
	`VPC_NEVER(a_last_gap, clk, arst_n, out_valid_q && !out_q.run_last && (cnt_q == '0), "run ended without last mark")

endmodule

`default_nettype wire

[rtl/varint_phrase_codec.sv]
// ---------------------------------------------------------------------------
// varint_phrase_codec
// Phrase codec for 32-bit word ids as LEB128 varints of word+1, 0x00 ends.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data write direction_mode (0 encode, 1 decode);
//   cfg_ready is always high. Write it only while the block is idle.
//   Input items arrive on in_valid/in_stall/in_item, results leave on
//   out_valid/out_stall/out_item; an item moves when valid is high and
//   stall is low.
//   An accepted item becomes its whole result run combinationally and is
//   loaded into the run register; its first result then moves on through
//   the output register to out_item. The output register sends one result
//   per cycle while out_stall is low, so an encode item with n results (up
//   to six) holds the input; decode items (one result at most) flow at one
//   item per cycle unless stalled. A new item is taken in the cycle in which
//   the last result of the previous run moves into the output register.
//   When the receiver stalls, out_item holds and in_stall rises once the run
//   register is full. Reset clears the run, the output valid, the decode
//   group state and sets encode mode.
// ---------------------------------------------------------------------------
`default_nettype none

module varint_phrase_codec
	import vpc_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_valid,
	output logic            cfg_ready,
	input  wire             cfg_data,
	input  wire             in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire             out_stall,
	output out_item_t       out_item
);

	dir_mode_t mode_q;
	logic      can_load;
	logic      in_take;
	run_t      enc_run;
	run_t      dec_run;
	run_t      run_sel;

	// direction register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= dir_mode_t'(cfg_data);
		end
	end

	// input handshake
	assign in_stall = !can_load;
	assign in_take  = in_valid && can_load;

	vpc_encode u_encode (
		.item (in_item),
		.run  (enc_run)
	);

	vpc_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_take && (mode_q == MODE_DECODE)),
		.in_byte (in_item.in_byte),
		.run     (dec_run)
	);

	// pick the run for the current direction
	assign run_sel = (mode_q == MODE_DECODE) ? dec_run : enc_run;

	vpc_run_buf u_run_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_take),
		.run       (run_sel),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

[tb/tb_varint_phrase_codec.sv]
// ---------------------------------------------------------------------------
// tb_varint_phrase_codec
// Self-checking bench for the varint phrase codec. A cycle-level predictor
// tracks the direction mode and the decode group state, and queues the
// results that each accepted item should cause. A checker compares every
// output item with the oldest queued result, field by field. Directed items
// cover the encode and decode corner cases, then random phrases run under
// random idling on both sides and one long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_varint_phrase_codec;
	import vpc_pkg::*;

	localparam int unsigned IdlePct     = 31;
	localparam int unsigned DrainCycles = 8;
	localparam int unsigned HoldCycles  = 150;
	localparam int unsigned QuietLimit  = 1000;
	localparam logic [7:0]  TopGroupByte = 8'h10;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// predictor state
	dir_mode_t          codec_mode;
	logic [WordW-1:0]   group_acc;
	logic [ShiftW-1:0]  group_shift;
	logic               group_open;
	out_item_t          pending_results[$];

	int unsigned tx_idle_pct  = IdlePct;
	int unsigned rx_stall_pct = IdlePct;
	int unsigned hold_request = 0;
	int unsigned items_sent   = 0;
	int unsigned enc_items    = 0;
	int unsigned dec_items    = 0;
	int unsigned results_seen = 0;
	int unsigned cfg_writes   = 0;
	int unsigned fail_count   = 0;

	varint_phrase_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one expected result, run_last set later for the final one of an item
	function automatic out_item_t mk_result(input logic [7:0] b, input logic [WordW-1:0] w,
			input logic valid, input logic done);
		out_item_t r;
		r.out_byte    = b;
		r.out_word    = w;
		r.word_valid  = valid;
		r.phrase_done = done;
		r.run_last    = 1'b0;
		return r;
	endfunction

	// append one expected result behind the others
	function automatic void queue_result(input out_item_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic void clear_group();
		group_acc   = '0;
		group_shift = '0;
		group_open  = 1'b0;
	endfunction

	// work out the results of one accepted item and queue them
	function automatic void predict_codec_results(input in_item_t it);
		logic [WordW-1:0] v;
		int unsigned      n;
		int unsigned      k;
		n = 0;
		if (codec_mode == MODE_ENCODE) begin
			if (it.has_word) begin
				v = it.in_word + 1'b1;
				if (v == '0) begin
					// wrapped word: four empty continuation groups then the top group
					for (k = 0; k < 4; k++) begin
						queue_result(mk_result(ContBit, '0, 1'b0, 1'b0));
						n++;
					end
					queue_result(mk_result(TopGroupByte, '0, 1'b0, 1'b0));
					n++;
				end else begin
					while (v >= WordW'(ContBit)) begin
						queue_result(
							mk_result(ContBit | {1'b0, v[6:0]}, '0, 1'b0, 1'b0));
						n++;
						v = v >> 7;
					end
					queue_result(mk_result({1'b0, v[6:0]}, '0, 1'b0, 1'b0));
					n++;
				end
			end
			if (it.close_phrase) begin
				queue_result(mk_result(Terminator, '0, 1'b0, 1'b1));
				n++;
			end
		end else begin
			if (it.in_byte == Terminator) begin
				if (group_open)
					queue_result(mk_result('0, group_acc - 1'b1, 1'b1, 1'b1));
				else
					queue_result(mk_result('0, '0, 1'b0, 1'b1));
				n++;
				clear_group();
			end else begin
				// payload bits past bit 31 fall off the top
				if (group_shift < 6'd32)
					group_acc = group_acc | (WordW'(it.in_byte & PayloadMask) << group_shift);
				if ((it.in_byte & ContBit) == '0) begin
					queue_result(mk_result('0, group_acc - 1'b1, 1'b1, 1'b0));
					n++;
					clear_group();
				end else begin
					group_open = 1'b1;
					if (group_shift < ShiftLimit)
						group_shift = group_shift + ShiftStep;
				end
			end
		end
		if (n > 0)
			pending_results[$].run_last = 1'b1;
	endfunction

	function automatic in_item_t enc_item(input logic [WordW-1:0] w, input logic has,
			input logic close);
		in_item_t it;
		it.in_word      = w;
		it.has_word     = has;
		it.close_phrase = close;
		it.in_byte      = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t dec_item(input logic [7:0] b);
		in_item_t it;
		it.in_word      = $urandom;
		it.has_word     = 1'($urandom);
		it.close_phrase = 1'($urandom);
		it.in_byte      = b;
		return it;
	endfunction

	// word ids spread over one to five byte lengths, plus the two largest
	function automatic logic [WordW-1:0] pick_word();
		int unsigned grp;
		logic [63:0] mask;
		grp = $urandom_range(5);
		if (grp == 5)
			return $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
		mask = (64'h1 << (7 * (grp + 1))) - 1;
		return $urandom & mask[WordW-1:0];
	endfunction

	// offer one item, holding it until the block takes it
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_codec_results(it);
		items_sent++;
		if (codec_mode == MODE_ENCODE)
			enc_items++;
		else
			dec_items++;
	endtask

	// drain the block, then write direction_mode
	task automatic write_direction(input dir_mode_t m);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		codec_mode = m;
		cfg_writes++;
	endtask

	task automatic test_encode_directed();
		write_direction(MODE_ENCODE);
		send_item(enc_item(32'h0000_0000, 1'b1, 1'b0));
		send_item(enc_item(32'h0000_007F, 1'b1, 1'b0));
		send_item(enc_item(32'hFFFF_FFFE, 1'b1, 1'b0));
		send_item(enc_item(32'hFFFF_FFFF, 1'b1, 1'b0));
		// empty item, nothing comes out
		send_item(enc_item(32'h1234_5678, 1'b0, 1'b0));
		send_item(enc_item(32'hFFFF_FFFF, 1'b0, 1'b1));
		send_item(enc_item(32'hFFFF_FFFF, 1'b1, 1'b1));
		send_item(enc_item(32'h0000_007E, 1'b1, 1'b1));
	endtask

	task automatic test_decode_directed();
		write_direction(MODE_DECODE);
		// terminator outside a group, one-byte words
		send_item(dec_item(Terminator));
		send_item(dec_item(8'h01));
		send_item(dec_item(8'h7F));
		// terminator closing an open group
		send_item(dec_item(8'h80));
		send_item(dec_item(Terminator));
		// largest non-wrapping value
		repeat (4) send_item(dec_item(8'hFF));
		send_item(dec_item(8'h0F));
		// wrapped word comes back as all ones
		repeat (4) send_item(dec_item(ContBit));
		send_item(dec_item(TopGroupByte));
		// overlong group, shift saturates
		repeat (6) send_item(dec_item(8'hFF));
		send_item(dec_item(8'h7F));
		send_item(dec_item(Terminator));
	endtask

	task automatic test_mode_switch_keeps_group();
		write_direction(MODE_DECODE);
		send_item(dec_item(8'h85));
		write_direction(MODE_ENCODE);
		send_item(enc_item(pick_word(), 1'b1, 1'b1));
		send_item(enc_item(pick_word(), 1'b1, 1'b0));
		write_direction(MODE_DECODE);
		// finishes the group opened before the switch
		send_item(dec_item(8'h01));
		send_item(dec_item(Terminator));
	endtask

	task automatic test_encode_random(input int unsigned count);
		int unsigned k;
		write_direction(MODE_ENCODE);
		for (k = 0; k < count; k++) begin
			// stretch with no idling on either side
			if (k == count / 3) begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			if (k == count / 3 + 60) begin
				tx_idle_pct  = IdlePct;
				rx_stall_pct = IdlePct;
			end
			send_item(enc_item(pick_word(), $urandom_range(99) < 85, $urandom_range(3) == 0));
		end
	endtask

	task automatic test_decode_random(input int unsigned count);
		int unsigned start;
		int unsigned kind;
		int unsigned len;
		int unsigned k;
		write_direction(MODE_DECODE);
		start = items_sent;
		while (items_sent - start < count) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				// well-formed group, sometimes closing the phrase
				len = $urandom_range(1, 5);
				for (k = 1; k < len; k++)
					send_item(dec_item(ContBit | 8'($urandom_range(127))));
				send_item(dec_item(8'($urandom_range(127))));
				if ($urandom_range(3) == 0)
					send_item(dec_item(Terminator));
			end else if (kind < 88) begin
				send_item(dec_item(8'($urandom)));
			end else begin
				// overlong or cut-off group
				len = $urandom_range(6, 8);
				for (k = 0; k < len; k++)
					send_item(dec_item(ContBit | 8'($urandom_range(127))));
				if ($urandom_range(1))
					send_item(dec_item(Terminator));
				else
					send_item(dec_item(8'($urandom_range(127))));
			end
		end
	endtask

	task automatic test_output_backpressure(input int unsigned count);
		int unsigned k;
		write_direction(MODE_ENCODE);
		tx_idle_pct  = 0;
		hold_request = HoldCycles;
		for (k = 0; k < count; k++)
			send_item(enc_item(pick_word(), 1'b1, 1'b1));
		tx_idle_pct = IdlePct;
	endtask

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		codec_mode = MODE_ENCODE;
		clear_group();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_directed();
		test_decode_directed();
		test_mode_switch_keeps_group();
		test_encode_random(170);
		test_decode_random(220);
		test_output_backpressure(30);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("run: %0d items (%0d encode, %0d decode), %0d results, %0d mode writes",
			items_sent, enc_items, dec_items, results_seen, cfg_writes);
		$display("run: word lengths 1-5, wrap, terminators in and out of groups, overlong groups, hold-off");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off on request
	initial begin : rx_side
		int unsigned hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// compare one output item with the oldest queued result
	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			$error("result with nothing queued: out_byte=%02h out_word=%08h",
				got.out_byte, got.out_word);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.out_byte !== want.out_byte) begin
			$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
			fail_count++;
		end
		if (got.out_word !== want.out_word) begin
			$error("out_word: expected %08h, got %08h", want.out_word, got.out_word);
			fail_count++;
		end
		if (got.word_valid !== want.word_valid) begin
			$error("word_valid: expected %0b, got %0b", want.word_valid, got.word_valid);
			fail_count++;
		end
		if (got.phrase_done !== want.phrase_done) begin
			$error("phrase_done: expected %0b, got %0b", want.phrase_done, got.phrase_done);
			fail_count++;
		end
		if (got.run_last !== want.run_last) begin
			$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
			fail_count++;
		end
	endtask

	// result checker
	initial begin : result_monitor
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
				check_result(out_item);
		end
	end

	// watchdog on cycles with no traffic at all
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles, %0d results outstanding",
			QuietLimit, pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/vpc_pkg.sv
rtl/vpc_encode.sv
rtl/vpc_decode.sv
rtl/vpc_run_buf.sv
rtl/varint_phrase_codec.sv
tb/tb_varint_phrase_codec.sv
